// ===== src/xbf_pkg.sv =====
package xbf_pkg;

    localparam int unsigned POS_W       = 10;
    localparam int unsigned CRC_W       = 16;
    localparam int unsigned QUEUE_DEPTH = 2;

    localparam logic [7:0]       SOH_BYTE   = 8'h01;
    localparam logic [7:0]       STX_BYTE   = 8'h02;
    localparam logic [CRC_W-1:0] CRC_POLY   = 16'h1021;
    localparam logic [POS_W-1:0] SMALL_LAST = POS_W'(128 - 1);
    localparam logic [POS_W-1:0] LARGE_LAST = POS_W'(1024 - 1);

    typedef struct packed {
        logic             first;
        logic             last;
        logic             stx;
        logic [7:0]       number;
        logic [7:0]       data;
        logic [CRC_W-1:0] crc;
    } t_entry;

    // MSB-first shift of one byte into the CRC register
    function automatic logic [CRC_W-1:0] crc_byte(input logic [CRC_W-1:0] crc,
                                                  input logic [7:0] b);
        logic [CRC_W-1:0] c;
        logic             top;
        c = crc;
        for (int i = 7; i >= 0; i--) begin
            top = c[CRC_W-1];
            c   = {c[CRC_W-2:0], b[i]};
            if (top) begin
                c = c ^ CRC_POLY;
            end
        end
        return c;
    endfunction

endpackage

// ===== src/xbf_in_if.sv =====
interface xbf_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic [7:0] block_number;

    modport source (output valid, output data_byte, output block_number, input ready);
    modport sink   (input valid, input data_byte, input block_number, output ready);
endinterface

// ===== src/xbf_out_if.sv =====
interface xbf_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       block_end;

    modport source (output valid, output out_byte, output block_end, input ready);
    modport sink   (input valid, input out_byte, input block_end, output ready);
endinterface

// ===== src/xbf_cfg_if.sv =====
interface xbf_cfg_if;
    logic valid;
    logic ready;
    logic block_size_mode;

    modport source (output valid, output block_size_mode, input ready);
    modport sink   (input valid, input block_size_mode, output ready);
endinterface

// ===== src/xbf_front.sv =====
module xbf_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    xbf_cfg_if.sink         i_cfg,
    xbf_in_if.sink          i_in,
    input  logic            i_q_ready,
    output logic            o_push,
    output xbf_pkg::t_entry o_entry
);

    logic                           r_mode;
    logic [xbf_pkg::POS_W-1:0]      r_pos;
    logic [xbf_pkg::POS_W-1:0]      n_pos;
    logic [xbf_pkg::CRC_W-1:0]      r_crc;
    logic [xbf_pkg::CRC_W-1:0]      n_crc;
    logic [xbf_pkg::CRC_W-1:0]      crc_d;
    logic                           last;

    assign i_cfg.ready = 1'b1;
    assign i_in.ready  = i_q_ready;
    assign o_push      = i_in.valid && i_q_ready;

    assign crc_d = xbf_pkg::crc_byte(r_crc, i_in.data_byte);
    assign last  = r_mode ? (r_pos >= xbf_pkg::LARGE_LAST) : (r_pos >= xbf_pkg::SMALL_LAST);

    always_comb begin
        o_entry.first  = (r_pos == '0);
        o_entry.last   = last;
        o_entry.stx    = r_mode;
        o_entry.number = i_in.block_number;
        o_entry.data   = i_in.data_byte;
        o_entry.crc    = crc_d;
        n_pos = last ? '0 : r_pos + 1'b1;
        n_crc = last ? '0 : crc_d;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= 1'b0;
            r_pos  <= '0;
            r_crc  <= '0;
        end else begin
            if (i_cfg.valid) begin
                r_mode <= i_cfg.block_size_mode;
            end
            if (o_push) begin
                r_pos <= n_pos;
                r_crc <= n_crc;
            end
        end
    end

endmodule

// ===== src/xbf_fifo.sv =====
module xbf_fifo #(
    parameter int unsigned DEPTH = xbf_pkg::QUEUE_DEPTH
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  xbf_pkg::t_entry i_entry,
    output logic            o_ready,
    input  logic            i_pop,
    output logic            o_valid,
    output xbf_pkg::t_entry o_head
);

    localparam int unsigned PTR_W = $clog2(DEPTH);
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    xbf_pkg::t_entry    r_mem [DEPTH];
    logic [PTR_W-1:0]   r_wp;
    logic [PTR_W-1:0]   r_rp;
    logic [CNT_W-1:0]   r_cnt;

    assign o_ready = (r_cnt != CNT_W'(DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_head  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= (r_wp == PTR_W'(DEPTH - 1)) ? '0 : r_wp + 1'b1;
            end
            if (i_pop) begin
                r_rp <= (r_rp == PTR_W'(DEPTH - 1)) ? '0 : r_rp + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (i_pop && !i_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CNT_W'(DEPTH))
        else $error("queue count overflow");

    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> r_cnt != '0)
        else $error("pop from empty queue");

    a_push_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> r_cnt != CNT_W'(DEPTH))
        else $error("push into full queue");

endmodule

// ===== src/xbf_back.sv =====
module xbf_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_q_valid,
    input  xbf_pkg::t_entry i_head,
    output logic            o_pop,
    xbf_out_if.source       o_out
);

    localparam logic [2:0] ST_START = 3'd0;
    localparam logic [2:0] ST_HDR   = 3'd1;
    localparam logic [2:0] ST_NUM   = 3'd2;
    localparam logic [2:0] ST_CMP   = 3'd3;
    localparam logic [2:0] ST_DATA  = 3'd4;
    localparam logic [2:0] ST_HI    = 3'd5;
    localparam logic [2:0] ST_LO    = 3'd6;

    logic [2:0]                  r_ph;
    logic [2:0]                  n_ph;
    logic [2:0]                  cur;
    logic [xbf_pkg::CRC_W-1:0]   r_fcrc;
    logic [xbf_pkg::CRC_W-1:0]   n_fcrc;
    logic [xbf_pkg::CRC_W-1:0]   zs_src;
    logic [xbf_pkg::CRC_W-1:0]   zs;
    logic                        r_ovalid;
    logic [7:0]                  r_obyte;
    logic                        r_oend;
    logic [7:0]                  n_byte;
    logic                        n_end;
    logic                        produce;

    assign o_out.valid     = r_ovalid;
    assign o_out.out_byte  = r_obyte;
    assign o_out.block_end = r_oend;

    assign produce = (!r_ovalid || o_out.ready) && i_q_valid;
    assign cur     = (r_ph == ST_START) ? (i_head.first ? ST_HDR : ST_DATA) : r_ph;

    // one zero byte of the CRC flush per cycle in which an output byte is produced
    assign zs_src = (cur == ST_DATA) ? i_head.crc : r_fcrc;
    assign zs     = xbf_pkg::crc_byte(zs_src, 8'h00);

    always_comb begin
        n_ph   = r_ph;
        n_fcrc = r_fcrc;
        n_byte = i_head.data;
        n_end  = 1'b0;
        o_pop  = 1'b0;
        case (cur)
            ST_HDR: begin
                n_byte = i_head.stx ? xbf_pkg::STX_BYTE : xbf_pkg::SOH_BYTE;
                n_ph   = ST_NUM;
            end
            ST_NUM: begin
                n_byte = i_head.number;
                n_ph   = ST_CMP;
            end
            ST_CMP: begin
                n_byte = ~i_head.number;
                n_ph   = ST_DATA;
            end
            ST_DATA: begin
                n_byte = i_head.data;
                n_fcrc = zs;
                if (i_head.last) begin
                    n_ph = ST_HI;
                end else begin
                    n_ph  = ST_START;
                    o_pop = produce;
                end
            end
            ST_HI: begin
                n_byte = zs[15:8];
                n_fcrc = zs;
                n_ph   = ST_LO;
            end
            ST_LO: begin
                n_byte = r_fcrc[7:0];
                n_end  = 1'b1;
                n_ph   = ST_START;
                o_pop  = produce;
            end
            default: begin
                n_ph = ST_START;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ph     <= ST_START;
            r_ovalid <= 1'b0;
        end else if (produce) begin
            r_ph     <= n_ph;
            r_ovalid <= 1'b1;
        end else if (o_out.ready) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (produce) begin
            r_fcrc  <= n_fcrc;
            r_obyte <= n_byte;
            r_oend  <= n_end;
        end
    end

    a_lo_on_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        produce && cur == ST_LO |-> i_head.last)
        else $error("crc trailer on a non-final entry");

    a_hdr_on_first: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        produce && cur == ST_HDR |-> i_head.first)
        else $error("header on a non-first entry");

    a_hi_then_lo: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        produce && cur == ST_HI |=> r_ph == ST_LO)
        else $error("crc high byte not followed by low byte");

endmodule

// ===== src/xmodem_block_framer_crc16.sv =====
// XMODEM/YMODEM block framer. Each accepted payload byte leaves as one output
// byte; the first byte of a block is preceded by SOH (128-byte mode) or STX
// (1024-byte mode), the block number and its complement, and the last byte is
// followed by the CRC-16 (poly 0x1021, init 0) high and low bytes, the low
// byte flagged with block_end. Input is taken at one byte per cycle while the
// small queue between the intake and the output sequencer has room, and the
// sequencer sends one byte per cycle unless the queue is empty or the sink
// stalls, so the output side sets the sustained rate. The user must write
// block_size_mode via the cfg channel only while idle; it is not enforced.
module xmodem_block_framer_crc16 #(
    parameter int unsigned QUEUE_DEPTH = xbf_pkg::QUEUE_DEPTH
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    xbf_cfg_if.sink   i_cfg,
    xbf_in_if.sink    i_in,
    xbf_out_if.source o_out
);

    logic            q_ready;
    logic            q_valid;
    logic            push;
    logic            pop;
    xbf_pkg::t_entry entry;
    xbf_pkg::t_entry head;

    xbf_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (i_cfg),
        .i_in      (i_in),
        .i_q_ready (q_ready),
        .o_push    (push),
        .o_entry   (entry)
    );

    xbf_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_entry (entry),
        .o_ready (q_ready),
        .i_pop   (pop),
        .o_valid (q_valid),
        .o_head  (head)
    );

    xbf_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .i_head    (head),
        .o_pop     (pop),
        .o_out     (o_out)
    );

endmodule

// ===== tb/sv/xbf_checker.sv =====
module xbf_checker (
    input  logic i_clk,
    input  logic i_rst_n,
    xbf_cfg_if   cfg_ch,
    xbf_in_if    pay_ch,
    xbf_out_if   wire_ch,
    output int   o_fail_count,
    output int   o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int SMALL_BLOCK = 128;
    localparam int LARGE_BLOCK = 1024;
    localparam int MAX_REPORTS = 10;

    typedef struct packed {
        logic [7:0] wire_byte;
        logic       last;
    } t_wire_byte;

    t_wire_byte  wire_q[$];
    logic        large_mode = 1'b0;
    logic [15:0] crc_acc    = '0;
    logic [9:0]  pos        = '0;
    int          errors     = 0;

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
    end

    // direct (non-augmented) form: equals the register after the two-zero-byte flush
    function automatic logic [15:0] crc16_update(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {b, 8'h00};
        for (int i = 0; i < 8; i++) begin
            c = c[15] ? ((c << 1) ^ xbf_pkg::CRC_POLY) : (c << 1);
        end
        return c;
    endfunction

    function automatic void expect_byte(input logic [7:0] b, input logic e);
        t_wire_byte item;
        item.wire_byte = b;
        item.last      = e;
        wire_q.push_back(item);
    endfunction

    function automatic void frame_byte(input logic [7:0] d, input logic [7:0] num);
        int size;
        size = large_mode ? LARGE_BLOCK : SMALL_BLOCK;
        if (pos == 0) begin
            expect_byte(large_mode ? xbf_pkg::STX_BYTE : xbf_pkg::SOH_BYTE, 1'b0);
            expect_byte(num, 1'b0);
            expect_byte(~num, 1'b0);
            crc_acc = '0;
        end
        expect_byte(d, 1'b0);
        crc_acc = crc16_update(crc_acc, d);
        if (int'(pos) + 1 >= size) begin
            expect_byte(crc_acc[15:8], 1'b0);
            expect_byte(crc_acc[7:0], 1'b1);
            crc_acc = '0;
            pos     = '0;
        end else begin
            pos = pos + 1'b1;
        end
    endfunction

    function automatic void check_wire(input logic [7:0] b, input logic e);
        t_wire_byte want;
        if (wire_q.size() == 0) begin
            errors++;
            if (errors <= MAX_REPORTS) begin
                $display("[%0t] unexpected transaction: out_byte %02h block_end %0b",
                         $time, b, e);
            end
        end else begin
            want = wire_q.pop_front();
            if (b !== want.wire_byte || e !== want.last) begin
                errors++;
                if (errors <= MAX_REPORTS) begin
                    $display("[%0t] mismatch: out_byte %02h block_end %0b, expected %02h %0b",
                             $time, b, e, want.wire_byte, want.last);
                end
            end
        end
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            wire_q.delete();
            large_mode = 1'b0;
            crc_acc    = '0;
            pos        = '0;
        end else begin
            if (cfg_ch.valid && cfg_ch.ready) begin
                large_mode = cfg_ch.block_size_mode;
            end
            if (pay_ch.valid && pay_ch.ready) begin
                frame_byte(pay_ch.data_byte, pay_ch.block_number);
            end
            if (wire_ch.valid && wire_ch.ready) begin
                check_wire(wire_ch.out_byte, wire_ch.block_end);
            end
        end
        o_pending    <= wire_q.size();
        o_fail_count <= errors;
    end

endmodule

// ===== tb/sv/xmodem_block_framer_crc16_tb.sv =====
module xmodem_block_framer_crc16_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int SMALL_BLOCK    = 128;
    localparam int LARGE_BLOCK    = 1024;
    localparam int NO_LIMIT       = 1 << 30;
    localparam int HOLD_CYCLES    = 400;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int TAIL_CYCLES    = 20;

    logic i_clk;
    logic i_rst_n;

    xbf_cfg_if cfg_ch();
    xbf_in_if  pay_ch();
    xbf_out_if wire_ch();

    int   chk_fail;
    int   chk_pending;
    bit   hold_req = 1'b0;
    int   blk_pos;
    int   blocks_done;
    int   burst_left;
    int   fill_kind;
    logic cur_mode;

    logic [7:0] corner_bytes [20] = '{
        8'h00, 8'hFF, 8'h80, 8'h01, 8'h7F, 8'hFE, 8'h55, 8'hAA, 8'h0F, 8'hF0,
        8'h10, 8'h08, 8'h04, 8'h02, 8'h40, 8'h20, 8'hC3, 8'h3C, 8'h00, 8'hFF
    };

    xmodem_block_framer_crc16 uut (
        .i_clk,
        .i_rst_n,
        .i_cfg (cfg_ch),
        .i_in  (pay_ch),
        .o_out (wire_ch)
    );

    xbf_checker chk (
        .i_clk,
        .i_rst_n,
        .cfg_ch,
        .pay_ch,
        .wire_ch,
        .o_fail_count (chk_fail),
        .o_pending    (chk_pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    function automatic int next_gap();
        int r;
        if (burst_left > 0) begin
            burst_left--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 3) begin
            burst_left = $urandom_range(20, 80);
            return 0;
        end
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 96) return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    task automatic send_byte(input logic [7:0] d, input logic [7:0] num);
        int gap;
        pay_ch.valid        <= 1'b1;
        pay_ch.data_byte    <= d;
        pay_ch.block_number <= num;
        do @(posedge i_clk); while (!pay_ch.ready);
        if (blk_pos + 1 >= (cur_mode ? LARGE_BLOCK : SMALL_BLOCK)) begin
            blk_pos = 0;
            blocks_done++;
        end else begin
            blk_pos++;
        end
        gap = next_gap();
        if (gap > 0) begin
            pay_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic feed(input int max_bytes, input int block_goal);
        logic [7:0] d;
        logic [7:0] num;
        for (int k = 0; k < max_bytes && blocks_done < block_goal; k++) begin
            if (blk_pos == 0) begin
                fill_kind = $urandom_range(0, 9);
                num       = (blocks_done == 1) ? 8'h00 : 8'($urandom);
            end else begin
                num = 8'($urandom);
            end
            case (fill_kind)
                0:       d = 8'h00;
                1:       d = 8'hFF;
                2:       d = 8'(blk_pos);
                default: d = 8'($urandom);
            endcase
            send_byte(d, num);
        end
    endtask

    // only once every framed byte has drained
    task automatic set_mode(input logic m);
        pay_ch.valid <= 1'b0;
        repeat (2) @(posedge i_clk);
        while (chk_pending != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
        cfg_ch.valid           <= 1'b1;
        cfg_ch.block_size_mode <= m;
        do @(posedge i_clk); while (!cfg_ch.ready);
        cfg_ch.valid <= 1'b0;
        cur_mode = m;
    endtask

    initial begin : stimulus
        i_rst_n                <= 1'b0;
        cfg_ch.valid           <= 1'b0;
        cfg_ch.block_size_mode <= 1'b0;
        pay_ch.valid           <= 1'b0;
        pay_ch.data_byte       <= '0;
        pay_ch.block_number    <= '0;
        blk_pos     = 0;
        blocks_done = 0;
        burst_left  = 0;
        fill_kind   = 3;
        cur_mode    = 1'b0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        set_mode(1'b0);
        for (int k = 0; k < 20; k++) begin
            send_byte(corner_bytes[k], (k == 0) ? 8'hFF : 8'($urandom));
        end

        // sink holds off while the rest of the block keeps coming
        pay_ch.valid <= 1'b0;
        hold_req     <= 1'b1;
        @(posedge i_clk);
        wait (!hold_req);
        burst_left = 120;
        feed(NO_LIMIT, 1);

        // large block with number zero, shrunk and grown again below 128
        set_mode(1'b1);
        feed(12, NO_LIMIT);
        set_mode(1'b0);
        feed(10, NO_LIMIT);
        set_mode(1'b1);
        feed(8, NO_LIMIT);

        pay_ch.valid <= 1'b0;
        repeat (2) @(posedge i_clk);
        while (chk_pending != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (chk_fail == 0 && chk_pending == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

    initial begin : sink_side
        int pick;
        wire_ch.ready <= 1'b0;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (hold_req) begin
                wire_ch.ready <= 1'b0;
                hold_req      <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end else begin
                pick = $urandom_range(0, 99);
                if (pick < 50) begin
                    wire_ch.ready <= 1'b1;
                    repeat ($urandom_range(1, 16)) @(posedge i_clk);
                end else if (pick < 60) begin
                    wire_ch.ready <= 1'b1;
                    repeat ($urandom_range(40, 150)) @(posedge i_clk);
                end else if (pick < 90) begin
                    wire_ch.ready <= 1'b0;
                    repeat ($urandom_range(1, 3)) @(posedge i_clk);
                end else begin
                    wire_ch.ready <= 1'b0;
                    repeat ($urandom_range(10, 40)) @(posedge i_clk);
                end
            end
        end
    end

    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if ((pay_ch.valid && pay_ch.ready) || (wire_ch.valid && wire_ch.ready)
                || (cfg_ch.valid && cfg_ch.ready)) begin
                quiet = 0;
            end else begin
                quiet++;
            end
        end
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
